// File: hdl/ffc_pkg.sv
// flat-field correction shared package: payload structs, codes and widths
// no dependencies
package ffc_pkg;

  localparam int PixelCount = 1048576;
  localparam int MaxFrames  = 4096;
  localparam int IdxW       = 20;
  localparam int SumW       = 28;
  localparam int NW         = 13;
  localparam int NumW       = 29;
  localparam int QW         = 16;

  localparam logic [1:0] CMD_CORRECT = 2'd0;
  localparam logic [1:0] CMD_WHITE   = 2'd1;
  localparam logic [1:0] CMD_DARK    = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_STORED  = 2'd2;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  typedef struct packed {
    logic [1:0]      cmd;
    logic [IdxW-1:0] pixel_index;
    logic [15:0]     sample;
    logic            first_frame;
    logic            last_sample;
  } in_item_t;

  typedef struct packed {
    logic [15:0] corrected;
    logic [1:0]  status;
  } out_item_t;

  // per-item control carried down the pipeline
  typedef struct packed {
    logic            vld;
    logic [1:0]      cmd;
    logic [IdxW-1:0] idx;
    logic [15:0]     sample;
    logic            first;
    logic            missing;
  } ctl_t;

endpackage

// File: hdl/ffc_ram.sv
// generic single-write, single-read synchronous ram with registered read
// no dependencies
module ffc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/ffc_div.sv
// pipelined restoring divider: quo = floor((2*65535*num + den) / (2*den)), num < den
// one quotient bit per stage; depends on ffc_pkg
module ffc_div import ffc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [NumW-1:0] num,
  input  logic [NumW-1:0] den,
  input  logic [17:0]     tag,
  output logic            out_vld,
  output logic [QW-1:0]   quo,
  output logic [17:0]     out_tag
);

  // divisor is 2*den; num < den keeps the quotient under 2^16, so the
  // dividend bits above the low 16 already sit below the divisor
  localparam int DW = NumW + 1;
  localparam int XW = QW + DW;

  logic [XW-1:0] x;
  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] dv_r  [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [17:0]   tag_r [QW+1];
  logic [QW:0]   vld_r;

  // 2*65535*num + den as shifts and adds
  assign x = (XW'(num) << 17) - (XW'(num) << 1) + XW'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[QW-1:0], in_vld};
  end

  always_ff @(posedge clk) begin
    logic [DW:0] t;
    rem_r[0] <= x[XW-1:QW];
    lo_r[0]  <= x[QW-1:0];
    dv_r[0]  <= {den, 1'b0};
    q_r[0]   <= '0;
    tag_r[0] <= tag;
    for (int s = 0; s < QW; s++) begin
      // shift in the next dividend bit, msb first
      t = {rem_r[s], lo_r[s][QW-1]};
      if (t >= {1'b0, dv_r[s]}) begin
        rem_r[s+1] <= DW'(t - {1'b0, dv_r[s]});
        q_r[s+1]   <= {q_r[s][QW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= t[DW-1:0];
        q_r[s+1]   <= {q_r[s][QW-2:0], 1'b0};
      end
      lo_r[s+1]  <= {lo_r[s][QW-2:0], 1'b0};
      dv_r[s+1]  <= dv_r[s];
      tag_r[s+1] <= tag_r[s];
    end
  end

  assign out_vld = vld_r[QW];
  assign quo     = q_r[QW];
  assign out_tag = tag_r[QW];

endmodule

// File: hdl/flat_field_correction_core.sv
// flat-field correction top level: reference sum memories, read-modify-write
// pipeline, divider and output queue; depends on ffc_pkg, ffc_ram, ffc_div
//
//  channel | ports                        | moves
//  in      | in_valid/in_ready/in_data    | in_item_t transaction
//  out     | out_valid/out_ready/out_data | out_item_t transaction
//  cfg     | cfg_we/cfg_wdata             | frame_count write
//
// one transaction per cycle sustained while out_ready holds; out_valid rises once
// the accepted item has passed the read, update and numerator stages, the divider
// input register, sixteen divider stages (one per quotient bit) and the queue write.
// reset clears flags, pipeline valids and the queue; sums are undefined until
// captured. in_ready drops once 31 transactions sit between input and queue
// output; forwarding covers captures of the same pixel one or two apart.
module flat_field_correction_core import ffc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_we,
  input  logic [NW-1:0]   cfg_wdata
);

  localparam int QDepth = 32;
  localparam int QAw    = $clog2(QDepth);

  logic [NW-1:0] frame_count_r;
  logic          bright_valid_r, dark_valid_r;
  ctl_t          s1_r, s2_r;
  logic [SumW-1:0] wsum_r, wsum2_r;
  logic [IdxW-1:0] widx_r, widx2_r;
  logic            wbr_r, wdk_r, wbr2_r, wdk2_r;
  logic [SumW-1:0] wsum_nxt, old;
  logic [SumW:0]   acc;

  logic [NW-1:0] n_eff;
  always_comb begin
    n_eff = frame_count_r;
    if (frame_count_r == '0) n_eff = NW'(1);
    if (frame_count_r > NW'(MaxFrames)) n_eff = NW'(MaxFrames);
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // flags update at accept time; correct items sample them in order
  logic bv_nxt, dv_nxt;
  always_comb begin
    bv_nxt = bright_valid_r;
    dv_nxt = dark_valid_r;
    if (in_fire && in_data.cmd == CMD_WHITE) begin
      if (in_data.first_frame) bv_nxt = 1'b0;
      if (in_data.last_sample) bv_nxt = 1'b1;
    end
    if (in_fire && in_data.cmd == CMD_DARK) begin
      if (in_data.first_frame) dv_nxt = 1'b0;
      if (in_data.last_sample) dv_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r  <= NW'(1);
      bright_valid_r <= 1'b0;
      dark_valid_r   <= 1'b0;
      s1_r.vld       <= 1'b0;
      s2_r.vld       <= 1'b0;
      wbr_r          <= 1'b0;
      wdk_r          <= 1'b0;
      wbr2_r         <= 1'b0;
      wdk2_r         <= 1'b0;
    end else begin
      if (cfg_we) frame_count_r <= cfg_wdata;
      bright_valid_r <= bv_nxt;
      dark_valid_r   <= dv_nxt;
      s1_r.vld       <= in_fire;
      s1_r.cmd       <= in_data.cmd;
      s1_r.idx       <= in_data.pixel_index;
      s1_r.sample    <= in_data.sample;
      s1_r.first     <= in_data.first_frame;
      s1_r.missing   <= !(bright_valid_r && dark_valid_r);
      s2_r           <= s1_r;
      wbr_r          <= s1_r.vld && s1_r.cmd == CMD_WHITE;
      wdk_r          <= s1_r.vld && s1_r.cmd == CMD_DARK;
      wbr2_r         <= wbr_r;
      wdk2_r         <= wdk_r;
    end
    widx_r  <= s1_r.idx;
    wsum_r  <= wsum_nxt;
    widx2_r <= widx_r;
    wsum2_r <= wsum_r;
  end

  logic [SumW-1:0] b_rd, d_rd, b_cur, d_cur;
  ffc_ram #(.Width(SumW), .Depth(PixelCount)) u_bright (
    .clk, .we(wbr_r), .waddr(widx_r), .wdata(wsum_r),
    .raddr(in_data.pixel_index), .rdata(b_rd)
  );
  ffc_ram #(.Width(SumW), .Depth(PixelCount)) u_dark (
    .clk, .we(wdk_r), .waddr(widx_r), .wdata(wsum_r),
    .raddr(in_data.pixel_index), .rdata(d_rd)
  );

  // the write one ahead has not reached the ram yet; the one two ahead
  // lands on the same edge the read was taken, so the read missed it
  always_comb begin
    b_cur = b_rd;
    d_cur = d_rd;
    if (wbr2_r && widx2_r == s1_r.idx) b_cur = wsum2_r;
    if (wdk2_r && widx2_r == s1_r.idx) d_cur = wsum2_r;
    if (wbr_r && widx_r == s1_r.idx) b_cur = wsum_r;
    if (wdk_r && widx_r == s1_r.idx) d_cur = wsum_r;
  end

  always_comb begin
    old = (s1_r.cmd == CMD_WHITE) ? b_cur : d_cur;
    acc = {1'b0, old} + (SumW+1)'(s1_r.sample);
    if (s1_r.first)    wsum_nxt = SumW'(s1_r.sample);
    else if (acc[SumW]) wsum_nxt = SumMax;
    else               wsum_nxt = acc[SumW-1:0];
  end

  // stage 2: numerator and denominator
  logic [NumW-1:0] num_r, den_r;
  logic            sat_r, zero_r;
  ctl_t            s3_r;
  logic [NumW-1:0] rawn;
  logic [SumW-1:0] bd;
  always_comb begin
    rawn = NumW'(s1_r.sample) * NumW'(n_eff);
    bd   = (b_cur > d_cur) ? b_cur - d_cur : '0;
    if (bd < SumW'(n_eff)) bd = SumW'(n_eff);
  end
  logic [NumW-1:0] rawn_r, d2_r, den2_r;
  always_ff @(posedge clk) begin
    rawn_r <= rawn;
    d2_r   <= NumW'(d_cur);
    den2_r <= NumW'(bd);
  end
  always_ff @(posedge clk) begin
    num_r  <= rawn_r - d2_r;
    den_r  <= den2_r;
    zero_r <= rawn_r <= d2_r;
    sat_r  <= (rawn_r > d2_r) && (rawn_r - d2_r >= den2_r);
    s3_r   <= rst_n ? s2_r : '0;
  end

  logic [17:0] tag_in, tag_out;
  logic        dv_out;
  logic [QW-1:0] q;
  logic [1:0]  st;
  always_comb begin
    st = ST_OK;
    if (s3_r.cmd == CMD_WHITE || s3_r.cmd == CMD_DARK) st = ST_STORED;
    else if (s3_r.missing) st = ST_MISSING;
  end
  assign tag_in = {st, (st != ST_OK) ? 16'h0 : zero_r ? 16'h0 :
                   sat_r ? 16'hffff : 16'h0};

  ffc_div u_div (
    .clk, .rst_n, .in_vld(s3_r.vld),
    .num(zero_r || sat_r || st != ST_OK ? NumW'(0) : num_r),
    .den(den_r), .tag(tag_in),
    .out_vld(dv_out), .quo(q), .out_tag(tag_out)
  );

  // output queue
  out_item_t       q_mem [QDepth];
  logic [QAw:0]    wp_r, rp_r, infl_r;
  out_item_t       res;
  assign res.status    = tag_out[17:16];
  assign res.corrected = (tag_out[17:16] != ST_OK) ? 16'h0 :
                         (tag_out[15:0] != 16'h0) ? tag_out[15:0] : q;

  logic out_fire;
  assign out_fire  = out_valid && out_ready;
  assign out_valid = wp_r != rp_r;
  assign out_data  = q_mem[rp_r[QAw-1:0]];
  assign in_ready  = infl_r < (QAw+1)'(QDepth - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; infl_r <= '0;
    end else begin
      if (dv_out) wp_r <= wp_r + 1'b1;
      if (out_fire) rp_r <= rp_r + 1'b1;
      infl_r <= infl_r + (QAw+1)'(in_fire) - (QAw+1)'(out_fire);
    end
    if (dv_out) q_mem[wp_r[QAw-1:0]] <= res;
  end

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd == CMD_WHITE && in_data.last_sample |=> bright_valid_r)
    else $error("bright flag not set");
  a_q: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> infl_r != '0) else $error("output without transaction");
  a_nofull: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= (QAw+1)'(QDepth)) else $error("queue overflow");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for flat_field_correction_core: queue-fed driver, monitor,
// in-bench predictor of the white/dark sums and correction; depends on ffc_pkg
module tb_top import ffc_pkg::*; ();

  localparam int WdogLimit = 3000;
  localparam int LongHold  = 400;
  localparam int PoolSize  = 24;

  // spare command code, decoded as a correct transaction
  localparam logic [1:0] CMD_SPARE = 2'd3;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  in_item_t        in_data;
  logic            out_valid;
  logic            out_ready;
  out_item_t       out_data;
  logic            cfg_we;
  logic [NW-1:0]   cfg_wdata;

  flat_field_correction_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // stimulus and expected results
  in_item_t  pending_q[$];
  out_item_t expected_q[$];

  // predictor state
  logic [SumW-1:0] white_sum[int];
  logic [SumW-1:0] dark_sum[int];
  logic            white_ok, dark_ok;
  logic [NW-1:0]   frames_reg;

  // generator bookkeeping
  int pool[PoolSize];

  int send_gap_max, recv_gap_max;
  int send_gap, recv_gap, hold_cnt;
  logic hold_req, hold_taken;
  int errors, n_accepted, n_results, n_ok, n_missing, n_stored, idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic [SumW-1:0] accumulate(logic [SumW-1:0] old, logic [15:0] s,
                                                 logic first);
    longint t;
    if (first) return SumW'(s);
    t = longint'(old) + longint'(s);
    if (t > longint'(SumMax)) t = longint'(SumMax);
    return SumW'(t);
  endfunction

  // updates the reference state and returns the result this transaction gives
  function automatic out_item_t correct_pixel(in_item_t it);
    out_item_t r;
    longint n, b, d, num, den;
    int idx;
    idx = int'(it.pixel_index);
    r.corrected = '0;
    r.status = ST_STORED;
    if (it.cmd == CMD_WHITE) begin
      if (it.first_frame) white_ok = 1'b0;
      white_sum[idx] = accumulate(white_sum.exists(idx) ? white_sum[idx] : '0,
                                  it.sample, it.first_frame);
      if (it.last_sample) white_ok = 1'b1;
    end else if (it.cmd == CMD_DARK) begin
      if (it.first_frame) dark_ok = 1'b0;
      dark_sum[idx] = accumulate(dark_sum.exists(idx) ? dark_sum[idx] : '0,
                                 it.sample, it.first_frame);
      if (it.last_sample) dark_ok = 1'b1;
    end else if (!white_ok || !dark_ok) begin
      r.status = ST_MISSING;
    end else begin
      r.status = ST_OK;
      n = longint'(frames_reg);
      if (n == 0) n = 1;
      if (n > MaxFrames) n = MaxFrames;
      b = longint'(white_sum[idx]);
      d = longint'(dark_sum[idx]);
      den = (b > d) ? b - d : 0;
      if (den < n) den = n;
      num = longint'(it.sample) * n;
      if (num <= d) r.corrected = '0;
      else if (num - d >= den) r.corrected = 16'hFFFF;
      else r.corrected = 16'((2 * 65535 * (num - d) + den) / (2 * den));
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        expected_q.insert(expected_q.size(), correct_pixel(in_data));
        n_accepted++;
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_data  <= pending_q.pop_front();
        in_valid <= 1'b1;
        send_gap <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    int gap;
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_gap   <= 0;
      hold_cnt   <= 0;
      hold_taken <= 1'b0;
    end else begin
      gap = recv_gap;
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction, status", out_data.status, -1);
        end else begin
          want = expected_q.pop_front();
          if (out_data.status != want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.corrected != want.corrected)
            report_mismatch("corrected", out_data.corrected, want.corrected);
          case (want.status)
            ST_OK:      n_ok++;
            ST_MISSING: n_missing++;
            default:    n_stored++;
          endcase
        end
        gap = $urandom_range(0, recv_gap_max);
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt   <= LongHold;
        out_ready  <= 1'b0;
        recv_gap   <= gap;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
        recv_gap  <= gap;
      end else if (gap > 0) begin
        recv_gap  <= gap - 1;
        out_ready <= 1'b0;
      end else begin
        recv_gap  <= 0;
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_q.size() == 0 && expected_q.size() == 0 && !in_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("flat_field_correction_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push(input logic [1:0] cmd, input int idx, input int s,
                      input logic first, input logic last);
    in_item_t it;
    it.cmd = cmd;
    it.pixel_index = IdxW'(idx);
    it.sample = 16'(s);
    it.first_frame = first;
    it.last_sample = last;
    pending_q.insert(pending_q.size(), it);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_frames(input int v);
    cfg_we    <= 1'b1;
    cfg_wdata <= NW'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    frames_reg = NW'(v);
  endtask

  // well-formed capture of both references over the pool, then mixed traffic
  task automatic run_phase(input int n, input int count, input int smax, input int rmax);
    int f, nf, p, r, s;
    drain();
    write_frames(n);
    send_gap_max = smax;
    recv_gap_max = rmax;
    nf = $urandom_range(2, 3);
    for (f = 0; f < nf; f++)
      for (p = 0; p < PoolSize; p++) begin
        push(CMD_WHITE, pool[p], $urandom_range(20000, 65535), f == 0,
             f == nf - 1 && p == PoolSize - 1);
        push(CMD_DARK, pool[p], $urandom_range(0, 20000), f == 0,
             f == nf - 1 && p == PoolSize - 1);
      end
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      p = pool[$urandom_range(0, PoolSize - 1)];
      s = (r < 10) ? ((r < 5) ? 0 : 65535) : $urandom_range(0, 65535);
      if (r < 70)      push(CMD_CORRECT, p, s, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      else if (r < 76) push(CMD_SPARE, p, s, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
      else if (r < 88) push($urandom_range(0, 1) ? CMD_WHITE : CMD_DARK, p, s, 1'b0, 1'b0);
      else if (r < 93) push($urandom_range(0, 1) ? CMD_WHITE : CMD_DARK, p, s, 1'b0, 1'b1);
      else             push($urandom_range(0, 1) ? CMD_WHITE : CMD_DARK, p, s, 1'b1,
                            1'($urandom_range(0, 1)));
    end
    // bring both references back to valid
    push(CMD_WHITE, pool[0], $urandom_range(0, 65535), 1'b0, 1'b1);
    push(CMD_DARK, pool[0], $urandom_range(0, 65535), 1'b0, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    white_ok = 1'b0;
    dark_ok = 1'b0;
    frames_reg = NW'(1);
    hold_req = 1'b0;
    send_gap_max = 17;
    recv_gap_max = 17;
    errors = 0; n_accepted = 0; n_results = 0;
    n_ok = 0; n_missing = 0; n_stored = 0; idle_cycles = 0;
    pool[0] = 0;
    pool[1] = PixelCount - 1;
    pool[2] = 20'h55555;
    pool[3] = 20'hAAAAA;
    for (int i = 4; i < PoolSize; i++) pool[i] = $urandom_range(1, PixelCount - 2);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: missing references, first-with-last, ratio extremes, command three
    write_frames(1);
    push(CMD_WHITE, 0, 65535, 1'b1, 1'b1);
    push(CMD_CORRECT, 0, 100, 1'b0, 1'b0);
    push(CMD_DARK, 0, 1000, 1'b1, 1'b0);
    push(CMD_CORRECT, 0, 100, 1'b0, 1'b0);
    push(CMD_DARK, 0, 0, 1'b0, 1'b1);
    push(CMD_CORRECT, 0, 0, 1'b0, 1'b0);
    push(CMD_CORRECT, 0, 999, 1'b0, 1'b0);
    push(CMD_CORRECT, 0, 1001, 1'b0, 1'b0);
    push(CMD_CORRECT, 0, 33000, 1'b0, 1'b0);
    push(CMD_CORRECT, 0, 65535, 1'b0, 1'b0);
    push(CMD_SPARE, 0, 40000, 1'b1, 1'b1);
    push(CMD_WHITE, PixelCount - 1, 500, 1'b1, 1'b1);
    push(CMD_DARK, PixelCount - 1, 500, 1'b1, 1'b1);
    push(CMD_CORRECT, PixelCount - 1, 500, 1'b0, 1'b0);
    push(CMD_CORRECT, PixelCount - 1, 501, 1'b0, 1'b0);
    push(CMD_CORRECT, PixelCount - 1, 65535, 1'b0, 1'b0);

    run_phase(1, 110, 17, 17);
    run_phase(4096, 110, 0, 0);
    run_phase(0, 110, 17, 3);
    // long output stall with the sender flat out
    run_phase(8191, 200, 0, 17);
    @(posedge clk);
    hold_req <= 1'b1;
    run_phase(3, 110, 3, 17);
    run_phase(2, 110, 17, 0);
    run_phase($urandom_range(5, 40), 110, 8, 8);

    drain();
    $display("%0d transactions in, %0d results: %0d corrected, %0d missing, %0d stored",
             n_accepted, n_results, n_ok, n_missing, n_stored);
    $display("frame counts 0, 1, 2, 3, 4096, 8191 and random; long output stall covered");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("flat_field_correction_core test passed");
    end else begin
      $display("flat_field_correction_core test failed");
    end
    $finish;
  end

endmodule
